// File: src/modbus_write_coil_frame_builder_top_macros.svh
// assertion macros used by the checker file
`ifndef MODBUS_WRITE_COIL_FRAME_BUILDER_TOP_MACROS_SVH
`define MODBUS_WRITE_COIL_FRAME_BUILDER_TOP_MACROS_SVH

// clocked assertion, switched off while reset is held
`define MWCFB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define MWCFB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/mwcfb_pkg.sv
// types, constants and crc helper for the write single coil frame builder
package mwcfb_pkg;

    localparam logic [7:0]  FUNC_WRITE_COIL = 8'h05;
    localparam logic [7:0]  COIL_ON_HIGH    = 8'hFF;
    localparam logic [7:0]  COIL_OFF_HIGH   = 8'h00;
    localparam logic [7:0]  VALUE_LOW       = 8'h00;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    // position of a byte within the frame, in transmit order
    typedef enum logic [2:0] {
        POS_SLAVE   = 3'd0,
        POS_FUNC    = 3'd1,
        POS_ADDR_HI = 3'd2,
        POS_ADDR_LO = 3'd3,
        POS_VAL_HI  = 3'd4,
        POS_VAL_LO  = 3'd5,
        POS_CRC_LO  = 3'd6,
        POS_CRC_HI  = 3'd7
    } t_byte_pos;

    // one finished request waiting for transmission
    typedef struct packed {
        logic [7:0]  slave_address;
        logic [15:0] coil_addr;
        logic        coil_on;
        logic [15:0] crc;
    } t_req;

    // queue fill status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // frame byte at a given position, crc bytes taken from the entry
    function automatic logic [7:0] frame_byte_at(input t_req req, input t_byte_pos pos);
        logic [7:0] b;
        case (pos)
            POS_SLAVE:   b = req.slave_address;
            POS_FUNC:    b = FUNC_WRITE_COIL;
            POS_ADDR_HI: b = req.coil_addr[15:8];
            POS_ADDR_LO: b = req.coil_addr[7:0];
            POS_VAL_HI:  b = req.coil_on ? COIL_ON_HIGH : COIL_OFF_HIGH;
            POS_VAL_LO:  b = VALUE_LOW;
            POS_CRC_LO:  b = req.crc[7:0];
            POS_CRC_HI:  b = req.crc[15:8];
            default:     b = VALUE_LOW;
        endcase
        return b;
    endfunction

    // crc-16/modbus update by one byte, lsb first
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: src/modbus_write_coil_frame_builder_top.sv
// top level of the modbus rtu write single coil request builder
// Each word taken on the slave side (slave address, coil address, on/off)
// becomes the eight-byte write single coil request on the master side:
// slave, 0x05, address high, address low, 0xFF/0x00, 0x00, crc low, crc
// high, with tlast on the crc high byte. The crc-16/modbus (init 0xFFFF,
// reflected poly 0xA001) runs over the first six bytes. The sustained rate
// is set by the byte-wide output register, which sends one frame byte per
// cycle while the master side is ready. The front end runs the crc one
// byte per cycle and hands the result to a two-entry queue, so the next
// request is taken while the previous frame is still going out. No state
// survives between requests; reset clears only the control registers
// (busy flag, byte positions, output valid, queue pointers and count).
module modbus_write_coil_frame_builder_top
    import mwcfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: request words
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [7:0] slave_address, [23:8] coil_addr,
                                     // [24] coil_on, [31:25] zero
    // master side: frame bytes
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] frame_byte
    output logic        o_m_tlast    // last_byte
);

    // front to queue
    logic      w_push;
    t_req      w_push_req;
    // queue to back
    t_req      w_head;
    t_q_status w_q_status;
    logic      w_pop;

    // crc front end, one header byte per cycle
    mwcfb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_tvalid),
        .o_ready         (o_s_tready),
        .i_slave_address (i_s_tdata[7:0]),
        .i_coil_addr     (i_s_tdata[23:8]),
        .i_coil_on       (i_s_tdata[24]),
        .i_q_status      (w_q_status),
        .o_push          (w_push),
        .o_push_req      (w_push_req)
    );

    // decouples crc work from byte transmission
    mwcfb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_req (w_push_req),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_status   (w_q_status)
    );

    // byte sequencer with registered output
    mwcfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_q_status   (w_q_status),
        .o_pop        (w_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_frame_byte (o_m_tdata),
        .o_last_byte  (o_m_tlast)
    );

endmodule

// File: src/mwcfb_front.sv
// front end: takes a request and runs the crc over the six header bytes
module mwcfb_front
    import mwcfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_slave_address,
    input  logic [15:0] i_coil_addr,
    input  logic        i_coil_on,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_req        o_push_req
);

    logic        r_busy;
    t_byte_pos   r_pos;
    t_req        r_req;
    logic [15:0] r_crc;

    logic        n_busy;
    t_byte_pos   n_pos;
    logic [15:0] n_crc;
    logic        w_last;
    logic        w_accept;

    assign n_crc    = crc_add_byte(r_crc, frame_byte_at(r_req, r_pos));
    assign w_last   = r_busy && (r_pos == POS_VAL_LO);
    assign o_push   = w_last && !i_q_status.full;
    assign o_ready  = !r_busy || o_push;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        o_push_req     = r_req;
        o_push_req.crc = n_crc;
    end

    always_comb begin
        n_busy = r_busy;
        n_pos  = r_pos;
        if (w_accept) begin
            n_busy = 1'b1;
            n_pos  = POS_SLAVE;
        end else if (o_push) begin
            n_busy = 1'b0;
        end else if (r_busy && !w_last) begin
            n_pos = t_byte_pos'(r_pos + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= POS_SLAVE;
        end else begin
            r_busy <= n_busy;
            r_pos  <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.slave_address <= i_slave_address;
            r_req.coil_addr     <= i_coil_addr;
            r_req.coil_on       <= i_coil_on;
            r_req.crc           <= CRC_INIT;
            r_crc               <= CRC_INIT;
        end else if (r_busy && !w_last) begin
            r_crc <= n_crc;
        end
    end

endmodule

// File: src/mwcfb_queue.sv
// two-entry queue of finished requests between front and back
module mwcfb_queue
    import mwcfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_req      i_push_req,
    input  logic      i_pop,
    output t_req      o_head,
    output t_q_status o_status
);

    t_req       r_ent [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       w_push;
    logic       w_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_head = r_ent[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wr_ptr] <= i_push_req;
        end
    end

endmodule

// File: src/mwcfb_back.sv
// back end: walks the queue head byte by byte into the output register
module mwcfb_back
    import mwcfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_head,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_frame_byte,
    output logic       o_last_byte
);

    t_byte_pos  r_pos;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    logic       w_load;
    logic       w_fire;

    assign w_load = !r_valid || i_ready;
    assign w_fire = w_load && !i_q_status.empty;
    assign o_pop  = w_fire && (r_pos == POS_CRC_HI);

    assign o_valid      = r_valid;
    assign o_frame_byte = r_byte;
    assign o_last_byte  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= POS_SLAVE;
        end else if (w_fire) begin
            r_valid <= 1'b1;
            r_pos   <= t_byte_pos'(r_pos + 3'd1);
        end else if (w_load) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_byte <= frame_byte_at(i_head, r_pos);
            r_last <= (r_pos == POS_CRC_HI);
        end
    end

endmodule

// File: src/mwcfb_checker.sv
// port-level checker for the frame builder, bound to the top level
`include "modbus_write_coil_frame_builder_top_macros.svh"

module mwcfb_checker
    import mwcfb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tlast
);

    t_byte_pos r_pos;
    logic      w_out_word;

    assign w_out_word = o_m_tvalid && i_m_tready;

    // position of the current output word within its frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_SLAVE;
        end else if (w_out_word) begin
            r_pos <= t_byte_pos'(r_pos + 3'd1);
        end
    end

    `MWCFB_ASSERT(a_stall_hold, i_clk, i_rst_n,
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast),
        "output word changed while stalled")

    `MWCFB_ASSERT(a_last_on_eighth, i_clk, i_rst_n,
        o_m_tvalid |-> (o_m_tlast == (r_pos == POS_CRC_HI)),
        "tlast not on the eighth byte")

    `MWCFB_ASSERT(a_func_code, i_clk, i_rst_n,
        o_m_tvalid && (r_pos == POS_FUNC) |-> (o_m_tdata == FUNC_WRITE_COIL),
        "second byte is not the write single coil code")

    `MWCFB_ASSERT(a_value_bytes, i_clk, i_rst_n,
        o_m_tvalid && (r_pos == POS_VAL_LO || r_pos == POS_VAL_HI) |->
            (o_m_tdata == VALUE_LOW || (r_pos == POS_VAL_HI && o_m_tdata == COIL_ON_HIGH)),
        "coil value bytes malformed")

endmodule

bind modbus_write_coil_frame_builder_top mwcfb_checker u_mwcfb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// File: tb/tb_modbus_write_coil_frame_builder_top.sv
// testbench for the modbus write single coil request builder, checked word by word
`timescale 1ns / 1ps

module tb_modbus_write_coil_frame_builder_top
    import mwcfb_pkg::*;
();

    // one frame byte as it should appear on the master side
    typedef struct {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_frame_word;

    // one directed request, with the whole frame typed in where it is well known
    typedef struct {
        logic [7:0]  slave_address;
        logic [15:0] coil_addr;
        logic        coil_on;
        bit          frame_known;
        logic [63:0] known_frame;   // byte 0 in [7:0], crc high in [63:56]
    } t_coil_request;

    localparam int NUM_DIRECTED = 14;

    // textbook frames head the table, the rest are predicted
    t_coil_request directed_requests [NUM_DIRECTED] = '{
        '{8'h01, 16'h0000, 1'b1, 1'b1, 64'h3A8C_00FF_0000_0501},
        '{8'h01, 16'h0000, 1'b0, 1'b1, 64'hCACD_0000_0000_0501},
        '{8'h11, 16'h00AC, 1'b1, 1'b1, 64'h8B4E_00FF_AC00_0511},
        '{8'h00, 16'h0000, 1'b0, 1'b0, 64'h0},
        '{8'hFF, 16'hFFFF, 1'b1, 1'b0, 64'h0},
        '{8'hFF, 16'hFFFF, 1'b0, 1'b0, 64'h0},
        '{8'h00, 16'hFFFF, 1'b1, 1'b0, 64'h0},
        '{8'hFF, 16'h0000, 1'b0, 1'b0, 64'h0},
        '{8'h55, 16'hAAAA, 1'b1, 1'b0, 64'h0},
        '{8'hAA, 16'h5555, 1'b0, 1'b0, 64'h0},
        '{8'h80, 16'h8000, 1'b1, 1'b0, 64'h0},
        '{8'h7F, 16'h7FFF, 1'b0, 1'b0, 64'h0},
        '{8'h01, 16'h0001, 1'b1, 1'b0, 64'h0},
        '{8'hFE, 16'hFFFE, 1'b1, 1'b0, 64'h0}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = 32'h0;   // [7:0] slave_address, [23:8] coil_addr,
                                       // [24] coil_on, [31:25] zero
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;            // [7:0] frame_byte
    logic        o_m_tlast;            // last_byte

    // frame bytes still owed by the block, oldest first
    t_frame_word pending_frame_bytes [$];
    int          mismatch_count = 0;
    int          byte_in_frame  = 0;
    bit          no_idle        = 1'b0;   // both sides run flat out while set
    bit          long_hold_req  = 1'b0;   // receiver backs off for a long stretch
    bit          reset_done     = 1'b0;

    modbus_write_coil_frame_builder_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #2 i_clk = ~i_clk;

    // crc-16/modbus over the six header bytes, shifted one bit at a time
    function automatic logic [15:0] header_crc(input logic [47:0] header);
        logic [15:0] crc;
        logic        feedback;
        crc = CRC_INIT;
        for (int i = 0; i < 48; i++) begin
            feedback = crc[0] ^ header[i];
            crc      = crc >> 1;
            if (feedback) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // whole request frame, byte 0 in the lowest bits
    function automatic logic [63:0] build_coil_request(input logic [7:0]  slave_address,
                                                       input logic [15:0] coil_addr,
                                                       input logic        coil_on);
        logic [47:0] header;
        header = {VALUE_LOW, (coil_on ? COIL_ON_HIGH : COIL_OFF_HIGH),
                  coil_addr[7:0], coil_addr[15:8], FUNC_WRITE_COIL, slave_address};
        return {header_crc(header), header};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // offer one request after a random gap, queue its frame once it is taken
    task automatic send_request(input logic [7:0]  slave_address,
                                input logic [15:0] coil_addr,
                                input logic        coil_on,
                                input bit          frame_known,
                                input logic [63:0] known_frame);
        int          gap;
        logic [63:0] frame;
        t_frame_word w;
        gap = no_idle ? 0 : int'($urandom_range(0, 13));
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'b0, coil_on, coil_addr, slave_address};
        do @(posedge i_clk); while (!o_s_tready);
        frame = frame_known ? known_frame
                            : build_coil_request(slave_address, coil_addr, coil_on);
        for (int i = 0; i < 8; i++) begin
            w.frame_byte = frame[8*i +: 8];
            w.last_byte  = (i == 7);
            pending_frame_bytes.push_back(w);
        end
    endtask

    task automatic send_random_requests(input int count);
        for (int n = 0; n < count; n++) begin
            send_request(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)), 1'b0, 64'h0);
        end
    endtask

    task automatic wait_frames_drained();
        while (pending_frame_bytes.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random back-pressure, one long hold on request, checks every word
    initial begin
        int          stall;
        t_frame_word want;
        wait (reset_done);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (250) @(posedge i_clk);
            end else begin
                stall = no_idle ? 0 : int'($urandom_range(0, 13));
                if (stall > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            if (pending_frame_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected word %02h last %0b",
                                          o_m_tdata, o_m_tlast));
            end else begin
                want = pending_frame_bytes.pop_front();
                if (o_m_tdata !== want.frame_byte) begin
                    report_mismatch($sformatf("byte %0d got %02h want %02h",
                                              byte_in_frame, o_m_tdata, want.frame_byte));
                end
                if (o_m_tlast !== want.last_byte) begin
                    report_mismatch($sformatf("byte %0d tlast got %0b want %0b",
                                              byte_in_frame, o_m_tlast, want.last_byte));
                end
                byte_in_frame = want.last_byte ? 0 : byte_in_frame + 1;
            end
        end
    end

    // sender and sequencing of the run
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reset_done = 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_request(directed_requests[i].slave_address,
                         directed_requests[i].coil_addr,
                         directed_requests[i].coil_on,
                         directed_requests[i].frame_known,
                         directed_requests[i].known_frame);
        end

        // sender stands back until every frame is out
        i_s_tvalid <= 1'b0;
        wait_frames_drained();

        send_random_requests(40);

        // long receiver hold while requests keep coming back to back
        long_hold_req = 1'b1;
        no_idle       = 1'b1;
        send_random_requests(30);
        no_idle       = 1'b0;

        i_s_tvalid <= 1'b0;
        wait_frames_drained();

        send_random_requests(50);
        i_s_tvalid <= 1'b0;

        wait_frames_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/mwcfb_pkg.sv
src/mwcfb_front.sv
src/mwcfb_queue.sv
src/mwcfb_back.sv
src/modbus_write_coil_frame_builder_top.sv
src/mwcfb_checker.sv
tb/tb_modbus_write_coil_frame_builder_top.sv
